[src/prim_mst_weight_sum_macros.svh]
// Assertion macros for the spanning tree weight block
`ifndef PRIM_MST_WEIGHT_SUM_MACROS_SVH
`define PRIM_MST_WEIGHT_SUM_MACROS_SVH

// same-cycle implication
`define PMST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmst assertion failed");

// next-cycle implication
`define PMST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmst assertion failed");

`endif

[src/pmst_pkg.sv]
// Package: constants and types for the spanning tree weight block
`timescale 1ns / 1ps
package pmst_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int FLD_W  = 6;
    localparam int CFG_W  = 7;
    localparam int SUM_W  = 32;
    localparam int EDGE_W = 2 * FLD_W + WEIGHT_BITS;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_COMPUTE = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_IDX = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef struct packed {
        logic                          found;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic [VIDX_W-1:0]             idx;
    } t_token;

    typedef struct packed {
        logic                          init;
        logic                          scan;
        logic                          visit;
        logic [VIDX_W-1:0]             visit_idx;
        logic                          upd;
        logic [VIDX_W-1:0]             upd_idx;
        logic signed [WEIGHT_BITS-1:0] upd_w;
    } t_cell_ctrl;
endpackage

[src/pmst_ram.sv]
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_addr,
    input  logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/pmst_cell.sv]
// Vertex cell: visited mark, best weight, and one stage of the min-search chain
`timescale 1ns / 1ps
module pmst_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [pmst_pkg::VIDX_W-1:0] i_idx,
    input  pmst_pkg::t_cell_ctrl  i_ctrl,
    input  pmst_pkg::t_token      i_tok,
    output pmst_pkg::t_token      o_tok
);
    import pmst_pkg::*;

    logic                          r_visited;
    logic                          r_valid;
    logic signed [WEIGHT_BITS-1:0] r_best;
    t_token                        r_tok;
    t_token                        n_tok;
    logic                          eligible;

    assign eligible = r_valid && !r_visited;

    always_comb begin
        n_tok = i_tok;
        if (eligible && (!i_tok.found || r_best < i_tok.weight)) begin
            n_tok.found  = 1'b1;
            n_tok.weight = r_best;
            n_tok.idx    = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= 1'b0;
            r_valid   <= 1'b0;
            r_tok     <= '0;
        end else begin
            if (i_ctrl.init) begin
                r_visited <= 1'b0;
                r_valid   <= (i_idx == '0);
                r_best    <= '0;
            end
            if (i_ctrl.visit && i_ctrl.visit_idx == i_idx) begin
                r_visited <= 1'b1;
            end
            if (i_ctrl.upd && i_ctrl.upd_idx == i_idx && !r_visited &&
                (!r_valid || i_ctrl.upd_w < r_best)) begin
                r_valid <= 1'b1;
                r_best  <= i_ctrl.upd_w;
            end
            if (i_ctrl.scan) begin
                r_tok <= n_tok;
            end
        end
    end

    assign o_tok = r_tok;
endmodule

[src/prim_mst_weight_sum.sv]
// Top level: edge store and Prim tree weight sum over a chain of vertex cells
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_stall   mode, source, target, weight
//  out      output     o_out_valid/i_out_stall tree_weight_sum, status
//  cfg      input      i_cfg_valid/o_cfg_ready vertex_count
//
// Clear, add and unused modes register their result in the cycle after acceptance.
// Compute: an init step, then rounds of a chain scan over all MAX_VERTICES cells,
// a pick and a sweep of the stored edges, and a done step at the end; there is
// one round per reachable vertex, and a last one that finds nothing ends at its pick.
// Reset is synchronous; edges are lost only on clear or reset.
// The input stalls while a compute runs or a result is held under output stall.
`timescale 1ns / 1ps
module prim_mst_weight_sum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic [pmst_pkg::FLD_W-1:0]   i_source_vertex,
    input  logic [pmst_pkg::FLD_W-1:0]   i_target_vertex,
    input  logic signed [pmst_pkg::WEIGHT_BITS-1:0] i_edge_weight,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [pmst_pkg::SUM_W-1:0] o_tree_weight_sum,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pmst_pkg::CFG_W-1:0]   i_cfg_data
);
    import pmst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_SCAN, S_PICK, S_EDGE, S_DONE
    } t_state;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_vcount;
    logic [ECNT_W-1:0]      r_etotal;
    logic [VIDX_W-1:0]      r_cnt;
    logic [VIDX_W-1:0]      r_pick;
    logic [ECNT_W-1:0]      r_ea;
    logic                   r_rv;
    logic [SUM_W-1:0]       r_acc;
    logic                   r_ov;
    logic [SUM_W-1:0]       r_sum;
    logic [1:0]             r_status;

    logic [CNT_W-1:0]       n_act;
    logic                   out_free;
    logic                   in_acc;
    logic                   ov_set;
    logic                   full;
    logic                   bad_idx;
    logic                   we;
    logic                   re;
    logic [EIDX_W-1:0]      addr;
    logic [EDGE_W-1:0]      wdata;
    logic [EDGE_W-1:0]      rdata;
    logic [FLD_W-1:0]       e_src;
    logic [FLD_W-1:0]       e_dst;
    logic signed [WEIGHT_BITS-1:0] e_w;
    t_cell_ctrl             ctrl;
    t_token                 tok [MAX_VERTICES+1];

    always_comb begin
        if (r_vcount == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            n_act = CNT_W'(MAX_VERTICES);
        end else begin
            n_act = CNT_W'(r_vcount);
        end
    end

    assign out_free    = !r_ov || !i_out_stall;
    assign o_in_stall  = !(r_state == S_IDLE && out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign ov_set      = (r_state == S_IDLE && in_acc && t_mode'(i_mode) != MODE_COMPUTE) ||
                         (r_state == S_DONE && out_free);
    assign o_cfg_ready = 1'b1;
    assign full        = (r_etotal == ECNT_W'(MAX_EDGES));
    assign bad_idx     = (32'(i_source_vertex) >= 32'(n_act)) ||
                         (32'(i_target_vertex) >= 32'(n_act));

    assign we    = in_acc && t_mode'(i_mode) == MODE_ADD && !full && !bad_idx;
    assign re    = (r_state == S_EDGE) && (r_ea < r_etotal);
    assign addr  = we ? EIDX_W'(r_etotal) : EIDX_W'(r_ea);
    assign wdata = {i_source_vertex, i_target_vertex, i_edge_weight};
    assign {e_src, e_dst, e_w} = rdata;

    pmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_re    (re),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_comb begin
        ctrl           = '0;
        ctrl.init      = (r_state == S_INIT);
        ctrl.scan      = (r_state == S_SCAN);
        ctrl.visit     = (r_state == S_PICK) && tok[MAX_VERTICES].found;
        ctrl.visit_idx = tok[MAX_VERTICES].idx;
        ctrl.upd       = (r_state == S_EDGE) && r_rv &&
                         (32'(e_src) == 32'(r_pick)) &&
                         (32'(e_dst) < 32'(n_act));
        ctrl.upd_idx   = VIDX_W'(e_dst);
        ctrl.upd_w     = e_w;
    end

    assign tok[0] = '0;

    for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
        pmst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (VIDX_W'(gi)),
            .i_ctrl  (ctrl),
            .i_tok   (tok[gi]),
            .o_tok   (tok[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= CFG_W'(MAX_VERTICES);
            r_etotal <= '0;
            r_ov     <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            r_ov <= ov_set || (r_ov && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sum <= '0;
                        unique case (t_mode'(i_mode))
                            MODE_CLEAR: begin
                                r_etotal <= '0;
                                r_status <= ST_OK;
                            end
                            MODE_ADD: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                end else if (bad_idx) begin
                                    r_status <= ST_BAD_IDX;
                                end else begin
                                    r_status <= ST_OK;
                                    r_etotal <= r_etotal + 1'b1;
                                end
                            end
                            MODE_COMPUTE: begin
                                r_acc   <= '0;
                                r_state <= S_INIT;
                            end
                            MODE_NONE: begin
                                r_status <= ST_OK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == VIDX_W'(MAX_VERTICES - 1)) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (tok[MAX_VERTICES].found) begin
                        r_pick  <= tok[MAX_VERTICES].idx;
                        r_acc   <= r_acc + SUM_W'(tok[MAX_VERTICES].weight);
                        r_ea    <= '0;
                        r_rv    <= 1'b0;
                        r_state <= S_EDGE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_EDGE: begin
                    r_rv <= re;
                    if (re) begin
                        r_ea <= r_ea + 1'b1;
                    end else if (!r_rv) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_sum    <= r_acc;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_ov;
    assign o_tree_weight_sum = r_sum;
    assign o_status          = r_status;
endmodule

[src/pmst_checker.sv]
// Port-level checker for the spanning tree weight block, bound to the top level
`timescale 1ns / 1ps
`include "prim_mst_weight_sum_macros.svh"
module pmst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [1:0]                   i_mode,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [pmst_pkg::SUM_W-1:0]   o_tree_weight_sum,
    input logic [1:0]                   o_status
);
    import pmst_pkg::*;

    `PMST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_tree_weight_sum) && $stable(o_status))
    `PMST_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, o_status != ST_RSVD)
    `PMST_ASSERT_IMP(a_refuse_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_tree_weight_sum == '0)
    `PMST_ASSERT_NXT(a_quick_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_mode != MODE_COMPUTE, o_out_valid)
endmodule

bind prim_mst_weight_sum pmst_checker u_pmst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_mode            (i_mode),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_tree_weight_sum (o_tree_weight_sum),
    .o_status          (o_status)
);
